### rtl/itcn_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and symbol codes for the integer to Chinese numerals block.
package itcn_pkg;

  localparam int GROUPS  = 4;
  localparam int VALUE_W = 55;
  localparam int MAG_W   = VALUE_W - 1;
  localparam int DIGITS  = 4 * GROUPS;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int SYM_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_ZERO     = 5'd0;
  localparam sym_t SYM_TEN      = 5'd10;
  localparam sym_t SYM_HUNDRED  = 5'd11;
  localparam sym_t SYM_THOUSAND = 5'd12;
  localparam sym_t SYM_LIANG    = 5'd16;
  localparam sym_t SYM_NEG      = 5'd17;

  // Register index of the liang mode bit.
  localparam logic REG_LIANG = 1'b0;

  function automatic logic [VALUE_W-1:0] itcn_limit();
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < GROUPS; i++) begin
      acc = acc * 64'd10000;
    end
    return acc[VALUE_W-1:0];
  endfunction

  localparam logic [VALUE_W-1:0] MAG_LIMIT = itcn_limit();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAT,
    ST_CONV,
    ST_NEG,
    ST_WALK,
    ST_ZERO
  } state_t;

  // Symbol positions visited within one group of four digits.
  typedef enum logic [3:0] {
    SL_GZERO,
    SL_TH,
    SL_QIAN,
    SL_HU,
    SL_BAI,
    SL_GAP1,
    SL_TE,
    SL_SHI,
    SL_GAP2,
    SL_ON,
    SL_UNIT
  } slot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

### rtl/itcn_bcd_conv.sv
`timescale 1ns / 1ps
// Iterative shift-add-3 binary to BCD converter, one bit per cycle.
module itcn_bcd_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [itcn_pkg::MAG_W-1:0]    bin,
  output itcn_pkg::conv_stat_t          stat,
  output logic [itcn_pkg::BCD_W-1:0]    bcd
);

  logic                          busy_r;
  logic                          done_r;
  logic [itcn_pkg::CNT_W-1:0]    cnt_r;
  logic [itcn_pkg::MAG_W-1:0]    bin_r;
  logic [itcn_pkg::BCD_W-1:0]    bcd_r;
  logic [itcn_pkg::BCD_W-1:0]    bcd_adj;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int d = 0; d < itcn_pkg::DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == itcn_pkg::CNT_W'(itcn_pkg::MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      {bcd_r, bin_r} <= {bcd_adj[itcn_pkg::BCD_W-2:0], bin_r, 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

### rtl/int_to_chinese_numerals.sv
`timescale 1ns / 1ps
// Order of work: a zero item goes straight to its single symbol; any other item first passes
// a 54-step BCD conversion, then a negative item emits its sign, and then the walk begins.
// One item at a time: a new item is taken only once the last one is finished, which is set by the
// one-bit-per-cycle converter and an 11-position walk over each of the 4 digit groups;
// output stalls lengthen it.
// Reset (synchronous, active low): idle, no result pending, liang mode on.
module int_to_chinese_numerals (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [itcn_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [itcn_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [itcn_pkg::ADDR_W-1:0]         paddr,
  input  logic [itcn_pkg::DATA_W-1:0]         pwdata,
  output logic [itcn_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  itcn_pkg::state_t               state_r, state_nxt;
  itcn_pkg::slot_t                slot_r, slot_nxt;
  logic [itcn_pkg::GRP_W-1:0]     gi_r, gi_nxt;
  logic                           zero_pend_r, zero_pend_nxt;
  logic                           any_r, any_nxt;
  logic                           neg_r;
  logic [itcn_pkg::VALUE_W-1:0]   mag_r;
  logic                           liang_en_r;
  logic                           out_valid_r;
  itcn_pkg::sym_t                 out_symbol_r;
  logic                           out_last_r;

  logic [itcn_pkg::VALUE_W-1:0]   raw_u;
  logic [itcn_pkg::VALUE_W-1:0]   mag_sat;
  logic                           conv_start;
  itcn_pkg::conv_stat_t           conv_stat;
  logic [itcn_pkg::BCD_W-1:0]     bcd;
  logic [15:0]                    grp_a [itcn_pkg::GROUPS];
  logic [itcn_pkg::GROUPS-1:0]    nz;
  logic [itcn_pkg::GRP_W-1:0]     high_idx, low_idx;
  logic [15:0]                    grp;
  logic [3:0]                     th, hu, te, on;
  logic                           gnz, lead, low0;
  logic                           emit_v, emit_last;
  itcn_pkg::sym_t                 emit_sym;
  logic                           out_ok, advance, cfg_wr;

  assign raw_u   = in_valid ? in_value : '0;
  assign mag_sat = (mag_r >= itcn_pkg::MAG_LIMIT) ? (itcn_pkg::MAG_LIMIT - 1'b1) : mag_r;
  assign conv_start = (state_r == itcn_pkg::ST_SAT) && (mag_r != '0);

  itcn_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (mag_sat[itcn_pkg::MAG_W-1:0]),
    .stat  (conv_stat),
    .bcd   (bcd)
  );

  // Group split and leading / trailing non-zero group.
  always_comb begin
    high_idx = '0;
    low_idx  = '0;
    for (int k = 0; k < itcn_pkg::GROUPS; k++) begin
      grp_a[k] = bcd[16*k +: 16];
      nz[k]    = |bcd[16*k +: 16];
    end
    for (int k = 0; k < itcn_pkg::GROUPS; k++) begin
      if (nz[k]) high_idx = itcn_pkg::GRP_W'(k);
    end
    for (int k = itcn_pkg::GROUPS - 1; k >= 0; k--) begin
      if (nz[k]) low_idx = itcn_pkg::GRP_W'(k);
    end
  end

  assign grp  = grp_a[gi_r];
  assign th   = grp[15:12];
  assign hu   = grp[11:8];
  assign te   = grp[7:4];
  assign on   = grp[3:0];
  assign gnz  = |grp;
  assign lead = (gi_r == high_idx);
  assign low0 = (gi_r == low_idx) && (gi_r == '0);

  assign out_ok  = !out_valid_r || out_ready;
  assign advance = !emit_v || out_ok;

  // Symbol decode for the current position.
  always_comb begin
    emit_v    = 1'b0;
    emit_sym  = itcn_pkg::SYM_ZERO;
    emit_last = 1'b0;
    unique case (state_r)
      itcn_pkg::ST_NEG: begin
        emit_v   = 1'b1;
        emit_sym = itcn_pkg::SYM_NEG;
      end
      itcn_pkg::ST_ZERO: begin
        emit_v    = 1'b1;
        emit_last = 1'b1;
      end
      itcn_pkg::ST_WALK: begin
        unique case (slot_r)
          itcn_pkg::SL_GZERO: begin
            emit_v = gnz && zero_pend_r && any_r;
          end
          itcn_pkg::SL_TH: begin
            emit_v   = (th != 4'd0) && !((th == 4'd1) && lead);
            emit_sym = ((th == 4'd2) && liang_en_r) ? itcn_pkg::SYM_LIANG : {1'b0, th};
          end
          itcn_pkg::SL_QIAN: begin
            emit_v    = (th != 4'd0);
            emit_sym  = itcn_pkg::SYM_THOUSAND;
            emit_last = low0 && (hu == 4'd0) && (te == 4'd0) && (on == 4'd0);
          end
          itcn_pkg::SL_HU: begin
            emit_v   = (hu != 4'd0);
            emit_sym = ((hu == 4'd2) && liang_en_r && (th == 4'd0)) ?
                       itcn_pkg::SYM_LIANG : {1'b0, hu};
          end
          itcn_pkg::SL_BAI: begin
            emit_v    = (hu != 4'd0);
            emit_sym  = itcn_pkg::SYM_HUNDRED;
            emit_last = low0 && (te == 4'd0) && (on == 4'd0);
          end
          itcn_pkg::SL_GAP1: begin
            emit_v = (te != 4'd0) && (hu == 4'd0) && (th != 4'd0);
          end
          itcn_pkg::SL_TE: begin
            // Tens 10..19 with no higher digit in the group drop the one.
            emit_v   = (te != 4'd0) && !((te == 4'd1) && (th == 4'd0) && (hu == 4'd0));
            emit_sym = ((te == 4'd2) && liang_en_r && (th == 4'd0) && (hu == 4'd0)) ?
                       itcn_pkg::SYM_LIANG : {1'b0, te};
          end
          itcn_pkg::SL_SHI: begin
            emit_v    = (te != 4'd0);
            emit_sym  = itcn_pkg::SYM_TEN;
            emit_last = low0 && (on == 4'd0);
          end
          itcn_pkg::SL_GAP2: begin
            emit_v = (on != 4'd0) && (te == 4'd0) && ((th != 4'd0) || (hu != 4'd0));
          end
          itcn_pkg::SL_ON: begin
            emit_v    = (on != 4'd0);
            emit_sym  = {1'b0, on};
            emit_last = low0;
          end
          itcn_pkg::SL_UNIT: begin
            emit_v    = gnz && (gi_r != '0);
            emit_sym  = itcn_pkg::SYM_THOUSAND + itcn_pkg::SYM_W'(gi_r);
            emit_last = (gi_r == low_idx);
          end
          default: begin
            emit_v = 1'b0;
          end
        endcase
      end
      default: begin
        emit_v = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itcn_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = itcn_pkg::ST_SAT;
      end
      itcn_pkg::ST_SAT: begin
        state_nxt = (mag_r == '0) ? itcn_pkg::ST_ZERO : itcn_pkg::ST_CONV;
      end
      itcn_pkg::ST_CONV: begin
        if (conv_stat.done) state_nxt = neg_r ? itcn_pkg::ST_NEG : itcn_pkg::ST_WALK;
      end
      itcn_pkg::ST_NEG: begin
        if (out_ok) state_nxt = itcn_pkg::ST_WALK;
      end
      itcn_pkg::ST_WALK: begin
        if (advance && (slot_r == itcn_pkg::SL_UNIT) && (gi_r == '0)) begin
          state_nxt = itcn_pkg::ST_IDLE;
        end
      end
      itcn_pkg::ST_ZERO: begin
        if (out_ok) state_nxt = itcn_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = itcn_pkg::ST_IDLE;
      end
    endcase
  end

  // Walk position over groups and symbol positions.
  always_comb begin
    gi_nxt        = gi_r;
    slot_nxt      = slot_r;
    zero_pend_nxt = zero_pend_r;
    any_nxt       = any_r;
    if (state_r == itcn_pkg::ST_CONV) begin
      gi_nxt        = itcn_pkg::GRP_W'(itcn_pkg::GROUPS - 1);
      slot_nxt      = itcn_pkg::SL_GZERO;
      zero_pend_nxt = 1'b0;
      any_nxt       = 1'b0;
    end else if ((state_r == itcn_pkg::ST_WALK) && advance) begin
      unique case (slot_r)
        itcn_pkg::SL_GZERO: slot_nxt = itcn_pkg::SL_TH;
        itcn_pkg::SL_TH:    slot_nxt = itcn_pkg::SL_QIAN;
        itcn_pkg::SL_QIAN:  slot_nxt = itcn_pkg::SL_HU;
        itcn_pkg::SL_HU:    slot_nxt = itcn_pkg::SL_BAI;
        itcn_pkg::SL_BAI:   slot_nxt = itcn_pkg::SL_GAP1;
        itcn_pkg::SL_GAP1:  slot_nxt = itcn_pkg::SL_TE;
        itcn_pkg::SL_TE:    slot_nxt = itcn_pkg::SL_SHI;
        itcn_pkg::SL_SHI:   slot_nxt = itcn_pkg::SL_GAP2;
        itcn_pkg::SL_GAP2:  slot_nxt = itcn_pkg::SL_ON;
        itcn_pkg::SL_ON:    slot_nxt = itcn_pkg::SL_UNIT;
        itcn_pkg::SL_UNIT: begin
          // A zero group leaves a pending ling for the next non-zero group.
          slot_nxt      = itcn_pkg::SL_GZERO;
          gi_nxt        = gi_r - 1'b1;
          zero_pend_nxt = !gnz;
          any_nxt       = any_r || gnz;
        end
        default: slot_nxt = itcn_pkg::SL_GZERO;
      endcase
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == itcn_pkg::REG_LIANG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itcn_pkg::ST_IDLE;
      liang_en_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) liang_en_r <= pwdata[0];
      if (emit_v && out_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gi_r        <= gi_nxt;
    slot_r      <= slot_nxt;
    zero_pend_r <= zero_pend_nxt;
    any_r       <= any_nxt;
    if (in_valid && in_ready) begin
      neg_r <= raw_u[itcn_pkg::VALUE_W-1];
      mag_r <= raw_u[itcn_pkg::VALUE_W-1] ? (~raw_u + 1'b1) : raw_u;
    end
    if (emit_v && out_ok) begin
      out_symbol_r <= emit_sym;
      out_last_r   <= emit_last;
    end
  end

  assign in_ready   = (state_r == itcn_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == itcn_pkg::REG_LIANG) ?
                      {{(itcn_pkg::DATA_W-1){1'b0}}, liang_en_r} : '0;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accepted item");

  a_conv_in_conv_state: assert property (@(posedge clk) disable iff (!rst_n)
    conv_stat.busy |-> (state_r == itcn_pkg::ST_CONV))
    else $error("converter running outside the conversion state");

  a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol <= itcn_pkg::SYM_NEG))
    else $error("symbol code out of range");

  a_walk_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == itcn_pkg::ST_WALK) && (slot_r == itcn_pkg::SL_UNIT) && (gi_r == '0)
      && advance) |=> in_ready)
    else $error("walk finished without returning to idle");

endmodule
